/* sv/assert_macros.svh */
// assertion macros shared by the prescaler search modules
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define TPS_ASSERT(label, clk, rst_n, prop)
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/tps_pkg.sv */
// types, constants and the prescaler table for the prescaler search
// no dependencies
package tps_pkg;

	localparam int TARGET_W  = 16;
	localparam int SEL_W     = 3;
	localparam int RELOAD_W  = 8;
	localparam int RATE_W    = 20;
	localparam int DIV_STEPS = RATE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int TIMER_CLOCK = 2457600;

	localparam logic [SEL_W-1:0] SEL_FIRST = 3'd7;
	localparam logic [SEL_W-1:0] SEL_LAST  = 3'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EVAL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [RATE_W-1:0] prescaled_clock(input logic [SEL_W-1:0] sel);
		logic [RATE_W-1:0] r;
		unique case (sel)
			3'd1: r = RATE_W'(TIMER_CLOCK / 4);
			3'd2: r = RATE_W'(TIMER_CLOCK / 10);
			3'd3: r = RATE_W'(TIMER_CLOCK / 16);
			3'd4: r = RATE_W'(TIMER_CLOCK / 50);
			3'd5: r = RATE_W'(TIMER_CLOCK / 64);
			3'd6: r = RATE_W'(TIMER_CLOCK / 100);
			3'd7: r = RATE_W'(TIMER_CLOCK / 200);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* sv/tps_divider.sv */
// bit-serial restoring divider: one quotient bit per cycle
// depends on tps_pkg and assert_macros.svh
`include "assert_macros.svh"

module tps_divider import tps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RATE_W-1:0]   dividend,
	input  logic [RELOAD_W-1:0] divisor,
	output div_stat_t           stat,
	output logic [RATE_W-1:0]   quotient
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RATE_W-1:0]   sr_q;
	logic [RELOAD_W-1:0] rem_q;
	logic [RELOAD_W-1:0] dvs_q;
	logic [RELOAD_W:0]   trial;
	logic [RELOAD_W:0]   diff;
	logic                qbit;

	assign trial = {rem_q, sr_q[RATE_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			sr_q  <= {sr_q[RATE_W-2:0], qbit};
			rem_q <= qbit ? diff[RELOAD_W-1:0] : trial[RELOAD_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = sr_q;

	`TPS_ASSERT(a_done_not_busy, clk, arst_n, !(done_q && busy_q))
	`TPS_ASSERT_IMPL(a_no_restart, clk, arst_n, busy_q, !start)
	`TPS_ASSERT_NEXT(a_done_follows, clk, arst_n, busy_q && !start && (cnt_q == CNT_W'(DIV_STEPS - 1)), done_q)

endmodule

/* sv/tps_search.sv */
// search sequencer: walks prescalers and reloads and keeps the closest pair
// depends on tps_pkg, tps_divider and assert_macros.svh
`include "assert_macros.svh"

module tps_search import tps_pkg::*; #(
	parameter int RELOAD_MAX = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [TARGET_W-1:0] target,
	input  logic                slot_free,
	output logic                idle,
	output logic                finish,
	output logic [SEL_W-1:0]    best_sel,
	output logic [RELOAD_W-1:0] best_reload,
	output logic [RATE_W-1:0]   best_rate
);

	state_t              state_q, state_d;
	logic [TARGET_W-1:0] target_q;
	logic [SEL_W-1:0]    sel_q;
	logic [RELOAD_W-1:0] reload_q;
	logic [RATE_W-1:0]   best_dist_q;
	logic [SEL_W-1:0]    best_sel_q;
	logic [RELOAD_W-1:0] best_reload_q;
	logic [RATE_W-1:0]   best_rate_q;

	logic                div_start;
	div_stat_t           div_stat;
	logic [RATE_W-1:0]   rate;
	logic [RATE_W-1:0]   tgt_ext;
	logic                rate_lt;
	logic [RATE_W-1:0]   cand_dist;
	logic                better;
	logic                scan_end;
	logic                init_search;
	logic                next_reload;
	logic                next_sel;

	tps_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prescaled_clock(init_search ? SEL_FIRST : (next_sel ? sel_q - 1'b1 : sel_q))),
		.divisor  (init_search || next_sel ? RELOAD_W'(1) : reload_q + 1'b1),
		.stat     (div_stat),
		.quotient (rate)
	);

	assign tgt_ext   = RATE_W'(target_q);
	assign rate_lt   = rate < tgt_ext;
	assign cand_dist = rate_lt ? tgt_ext - rate : rate - tgt_ext;
	// cand_dist never reaches all ones, so the all-ones start value loses every compare
	assign better    = cand_dist < best_dist_q;
	assign scan_end  = rate_lt || (reload_q == RELOAD_W'(RELOAD_MAX));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (go) state_d = ST_DIV;
			ST_DIV:  if (div_stat.done) state_d = ST_EVAL;
			ST_EVAL: begin
				if (scan_end && sel_q == SEL_LAST) state_d = ST_FIN;
				else state_d = ST_DIV;
			end
			ST_FIN:  if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		init_search = 1'b0;
		next_reload = 1'b0;
		next_sel    = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			ST_IDLE: init_search = go;
			ST_DIV:  ;
			ST_EVAL: begin
				next_sel    = scan_end && sel_q != SEL_LAST;
				next_reload = !scan_end;
			end
			ST_FIN:  finish = slot_free;
			default: ;
		endcase
		div_start = init_search || next_sel || next_reload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (init_search) begin
			target_q      <= target;
			sel_q         <= SEL_FIRST;
			reload_q      <= RELOAD_W'(1);
			best_dist_q   <= '1;
			best_sel_q    <= SEL_LAST;
			best_reload_q <= RELOAD_W'(1);
			best_rate_q   <= '0;
		end else if (state_q == ST_EVAL) begin
			if (better) begin
				best_dist_q   <= cand_dist;
				best_sel_q    <= sel_q;
				best_reload_q <= reload_q;
				best_rate_q   <= rate;
			end
			if (next_sel) begin
				sel_q    <= sel_q - 1'b1;
				reload_q <= RELOAD_W'(1);
			end else if (next_reload) begin
				reload_q <= reload_q + 1'b1;
			end
		end
	end

	assign idle        = (state_q == ST_IDLE);
	assign best_sel    = best_sel_q;
	assign best_reload = best_reload_q;
	assign best_rate   = best_rate_q;

	`TPS_ASSERT_IMPL(a_eval_after_done, clk, arst_n, state_q == ST_EVAL, $past(div_stat.done))
	`TPS_ASSERT_IMPL(a_start_when_free, clk, arst_n, div_start, !div_stat.busy)
	`TPS_ASSERT_IMPL(a_sel_in_range, clk, arst_n, state_q == ST_EVAL, sel_q != '0 && reload_q != '0)

endmodule

/* sv/timer_prescaler_search.sv */
// top level of the timer prescaler search with the result output register
// depends on tps_pkg, tps_search and tps_divider
// One request carries a target tick rate; the block tries every prescaler from
// index 7 down to 1 and reloads upward from 1, stopping a prescaler's scan at the
// first rate below the target or at RELOAD_MAX, and returns the closest pair and
// its rate. Each candidate goes through a bit-serial divider, whose done strobe
// moves the search on to compare it against the best so far. One request is
// worked on at a time; the next is taken once the result sits in the output
// register.
module timer_prescaler_search import tps_pkg::*; #(
	parameter int RELOAD_MAX = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                target_valid,
	output logic                target_stall,
	input  logic [TARGET_W-1:0] target_rate,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [SEL_W-1:0]    prescale_select,
	output logic [RELOAD_W-1:0] reload_value,
	output logic [RATE_W-1:0]   achieved_rate
);

	logic                idle;
	logic                finish;
	logic                slot_free;
	logic [SEL_W-1:0]    best_sel;
	logic [RELOAD_W-1:0] best_reload;
	logic [RATE_W-1:0]   best_rate;
	logic                result_valid_q;
	logic [SEL_W-1:0]    sel_q;
	logic [RELOAD_W-1:0] reload_q;
	logic [RATE_W-1:0]   rate_q;

	assign slot_free    = !result_valid_q || !result_stall;
	assign target_stall = !idle;

	tps_search #(
		.RELOAD_MAX (RELOAD_MAX)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (target_valid),
		.target      (target_rate),
		.slot_free   (slot_free),
		.idle        (idle),
		.finish      (finish),
		.best_sel    (best_sel),
		.best_reload (best_reload),
		.best_rate   (best_rate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else if (finish) result_valid_q <= 1'b1;
		else if (!result_stall) result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sel_q    <= best_sel;
			reload_q <= best_reload;
			rate_q   <= best_rate;
		end
	end

	assign result_valid    = result_valid_q;
	assign prescale_select = sel_q;
	assign reload_value    = reload_q;
	assign achieved_rate   = rate_q;

endmodule

/* tb/timer_prescaler_search_tb.sv */
// testbench for timer_prescaler_search: sends target rates and checks the chosen timer setting
// depends on tps_pkg and timer_prescaler_search; expected settings come from a local search model
module timer_prescaler_search_tb import tps_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RELOAD_LIMIT = 255;
	localparam int PRESCALE_DIV [1:7] = '{4, 10, 16, 50, 64, 100, 200};

	typedef struct packed {
		logic [SEL_W-1:0]    sel;
		logic [RELOAD_W-1:0] reload;
		logic [RATE_W-1:0]   rate;
	} timer_setting_t;

	logic                clk;
	logic                arst_n;
	logic                target_valid;
	logic                target_stall;
	logic [TARGET_W-1:0] target_rate;
	logic                result_valid;
	logic                result_stall;
	logic [SEL_W-1:0]    prescale_select;
	logic [RELOAD_W-1:0] reload_value;
	logic [RATE_W-1:0]   achieved_rate;

	timer_setting_t expected_settings[$];
	int unsigned    mismatches;
	int unsigned    rx_wait;
	logic           rx_quiet;
	logic           out_hold;
	bit             tx_quiet;

	timer_prescaler_search #(
		.RELOAD_MAX(RELOAD_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.target_valid(target_valid),
		.target_stall(target_stall),
		.target_rate(target_rate),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.prescale_select(prescale_select),
		.reload_value(reload_value),
		.achieved_rate(achieved_rate)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	function automatic timer_setting_t closest_setting(input logic [TARGET_W-1:0] target);
		timer_setting_t best;
		int unsigned    best_dist;
		int unsigned    base;
		int unsigned    rate;
		int unsigned    rate_err;
		best_dist   = 32'h00FF_FFFF;
		best.sel    = SEL_W'(1);
		best.reload = RELOAD_W'(1);
		best.rate   = '0;
		for (int s = 7; s >= 1; s--) begin
			base = TIMER_CLOCK / PRESCALE_DIV[s];
			for (int r = 1; r <= RELOAD_LIMIT; r++) begin
				rate = base / r;
				rate_err = (target > rate) ? target - rate : rate - target;
				if (rate_err < best_dist) begin
					best_dist   = rate_err;
					best.sel    = SEL_W'(s);
					best.reload = RELOAD_W'(r);
					best.rate   = RATE_W'(rate);
				end
				if (rate < target)
					break;
			end
		end
		return best;
	endfunction

	function automatic logic [TARGET_W-1:0] draw_target();
		// low targets scan every reload, so keep them rare
		if ($urandom_range(0, 7) == 0)
			return TARGET_W'($urandom_range(0, 65535));
		return TARGET_W'($urandom_range(2048, 65535));
	endfunction

	// receiver side stall
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
		else if (rx_wait != 0)
			rx_wait = rx_wait - 1;
		result_stall <= out_hold || (rx_wait != 0);
	end

	// result check
	always @(posedge clk) begin
		timer_setting_t exp_setting;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_settings.size() == 0) begin
				$error("unexpected result sel %0d reload %0d rate %0d",
					prescale_select, reload_value, achieved_rate);
				mismatches++;
			end else begin
				exp_setting = expected_settings.pop_front();
				if (prescale_select !== exp_setting.sel) begin
					$error("prescale_select expected %0d actual %0d",
						exp_setting.sel, prescale_select);
					mismatches++;
				end
				if (reload_value !== exp_setting.reload) begin
					$error("reload_value expected %0d actual %0d",
						exp_setting.reload, reload_value);
					mismatches++;
				end
				if (achieved_rate !== exp_setting.rate) begin
					$error("achieved_rate expected %0d actual %0d",
						exp_setting.rate, achieved_rate);
					mismatches++;
				end
			end
		end
	end

	task automatic send_target(input logic [TARGET_W-1:0] target);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			target_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		target_valid <= 1'b1;
		target_rate  <= target;
		@(posedge clk);
		while (target_stall) @(posedge clk);
		expected_settings.push_back(closest_setting(target));
	endtask

	task automatic wait_results_done();
		target_valid <= 1'b0;
		do @(posedge clk); while (expected_settings.size() != 0);
	endtask

	task automatic test_corner_targets();
		logic [TARGET_W-1:0] corners [$];
		corners = '{16'd0, 16'd1, 16'd47, 16'd48, 16'd2409, 16'd2410, 16'd9216,
			16'd12288, 16'd12289, 16'd24576, 16'd32768, 16'd38400, 16'd49152,
			16'h5555, 16'hAAAA, 16'd65535};
		foreach (corners[i])
			send_target(corners[i]);
	endtask

	task automatic test_back_to_back();
		tx_quiet = 1'b1;
		rx_quiet <= 1'b1;
		repeat (40) send_target(draw_target());
		tx_quiet = 1'b0;
		rx_quiet <= 1'b0;
	endtask

	task automatic test_random_targets();
		repeat (200) send_target(draw_target());
	endtask

	task automatic test_output_hold_off();
		out_hold <= 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				out_hold <= 1'b0;
			end
		join_none
		repeat (8) send_target(TARGET_W'($urandom_range(40000, 65535)));
	endtask

	task automatic test_sender_pause();
		repeat (10) send_target(draw_target());
		wait_results_done();
		repeat (10) send_target(draw_target());
	endtask

	initial begin
		arst_n       = 1'b0;
		target_valid = 1'b0;
		target_rate  = '0;
		result_stall = 1'b0;
		rx_quiet     = 1'b0;
		out_hold     = 1'b0;
		tx_quiet     = 1'b0;
		rx_wait      = 0;
		mismatches   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_targets();
		test_back_to_back();
		test_output_hold_off();
		test_random_targets();
		test_sender_pause();

		wait_results_done();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_settings.size() == 0) begin
			$display("timer_prescaler_search_tb passed");
		end else begin
			$display("timer_prescaler_search_tb failed");
		end
		$finish;
	end

	initial begin
		#2s;
		$display("timer_prescaler_search_tb failed");
		$finish;
	end

endmodule
